// ----- design/jrbd_pkg.sv -----
// ---------------------------------------------------------------------------
// jrbd_pkg
// Shared types and constants of the bounded random draw block.
// ---------------------------------------------------------------------------
`default_nettype none

package jrbd_pkg;

  localparam int unsigned JRBD_WIDTH = 32;

  localparam logic [31:0] JRBD_MAGIC      = 32'h1995_0801;
  localparam logic [31:0] JRBD_ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] JRBD_RESET_SEED = 32'd1;
  localparam logic [31:0] JRBD_PERCENT    = 32'd100;
  localparam logic [4:0]  JRBD_WARMUP     = 5'd20;
  localparam logic [4:0]  JRBD_DIV_LAST   = 5'(JRBD_WIDTH - 1);

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_BOUNDED = 2'd1,
    OP_RANGE   = 2'd2,
    OP_CHANCE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_WARM,
    ST_IDLE,
    ST_SCALE,
    ST_ROUND,
    ST_QUOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ----- design/jrbd_if.sv -----
// ---------------------------------------------------------------------------
// jrbd_if
// Valid/ready channels of the bounded random draw block: request, result and
// seed write.
// ---------------------------------------------------------------------------
`default_nettype none

interface jrbd_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic        [31:0] bound;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic signed [31:0] chance_percent;

  modport source (output valid, opcode, bound, range_low, range_high, chance_percent,
                  input ready);
  modport sink   (input valid, opcode, bound, range_low, range_high, chance_percent,
                  output ready);
endinterface

interface jrbd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        chance_hit;

  modport source (output valid, result_value, chance_hit, input ready);
  modport sink   (input valid, result_value, chance_hit, output ready);
endinterface

interface jrbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed_value;

  modport source (output valid, seed_value, input ready);
  modport sink   (input valid, seed_value, output ready);
endinterface

`default_nettype wire

// ----- design/jrbd_div.sv -----
// ---------------------------------------------------------------------------
// jrbd_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module jrbd_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  jrbd_pkg::div_req_t  req,
  output jrbd_pkg::div_sts_t  sts,
  output logic [31:0]         quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;

  logic [32:0] trial;
  logic [32:0] shifted;
  logic [31:0] rem_nxt;
  logic [31:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[31]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[32]) begin
      rem_nxt = trial[31:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = shifted[31:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == jrbd_pkg::JRBD_DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- design/jsf_random_bounded_draw.sv -----
// ---------------------------------------------------------------------------
// jsf_random_bounded_draw
// Jenkins small fast 32-bit generator with bounded, signed range and percent
// chance draws.
// ---------------------------------------------------------------------------
// One request is taken at a time and gives one result. A raw word, a zero
// bound, or a full signed span takes a generator word with no divide; an
// empty signed range returns its low bound. A bounded draw first divides all
// ones by the bound and then divides each generator word by that scale, both
// on one shared serial divider, drawing a new word for every rejected one.
// After reset and after every seed write the generator runs 20 warm-up rounds,
// one per cycle, before the next request is taken. A finished result waits in
// an output register while the next request is accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module jsf_random_bounded_draw (
  input  wire          clk,
  input  wire          rst_n,
  jrbd_req_if.sink     in_req,
  jrbd_rsp_if.source   out_rsp,
  jrbd_cfg_if.sink     cfg_wr
);

  jrbd_pkg::state_t state_r, state_nxt;

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [4:0]  warm_cnt_r;

  jrbd_pkg::op_t op_r;
  logic [31:0] n_r;
  logic [31:0] offset_r;
  logic [6:0]  limit_r;
  logic [31:0] scale_r;
  logic [31:0] value_r;
  logic        hit_r;

  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic        out_hit_r;

  jrbd_pkg::div_req_t div_req;
  jrbd_pkg::div_sts_t div_sts;
  logic [31:0]        div_q;

  // One generator round.
  logic [31:0] t_w, a_n, b_n, c_n, d_n;
  always_comb begin
    t_w = a_r - {b_r[4:0], b_r[31:5]};
    a_n = b_r ^ {c_r[14:0], c_r[31:15]};
    b_n = c_r + d_r;
    c_n = d_r + t_w;
    d_n = a_n + t_w;
  end

  // Request decode.
  logic          req_acc, cfg_acc, empty_rng, slot_free, reject;
  logic [31:0]   n_in, offset_in;
  logic [6:0]    limit_in;
  jrbd_pkg::op_t op_in;

  always_comb begin
    op_in     = jrbd_pkg::op_t'(in_req.opcode);
    empty_rng = (in_req.range_high < in_req.range_low);
    n_in      = '0;
    offset_in = '0;
    if (in_req.chance_percent[31]) begin
      limit_in = '0;
    end else if (in_req.chance_percent > $signed(jrbd_pkg::JRBD_PERCENT)) begin
      limit_in = jrbd_pkg::JRBD_PERCENT[6:0];
    end else begin
      limit_in = in_req.chance_percent[6:0];
    end
    unique case (op_in)
      jrbd_pkg::OP_RAW:     n_in = '0;
      jrbd_pkg::OP_BOUNDED: n_in = in_req.bound;
      jrbd_pkg::OP_RANGE: begin
        n_in      = in_req.range_high - in_req.range_low + 32'd1;
        offset_in = in_req.range_low;
      end
      jrbd_pkg::OP_CHANCE:  n_in = jrbd_pkg::JRBD_PERCENT;
      default:              n_in = '0;
    endcase
  end

  assign slot_free = !out_valid_r || out_rsp.ready;
  assign reject    = (div_q >= n_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jrbd_pkg::ST_WARM: begin
        if (warm_cnt_r == 5'd1) state_nxt = jrbd_pkg::ST_IDLE;
      end
      jrbd_pkg::ST_IDLE: begin
        if (cfg_wr.valid) begin
          state_nxt = jrbd_pkg::ST_WARM;
        end else if (in_req.valid) begin
          if (op_in == jrbd_pkg::OP_RANGE && empty_rng) state_nxt = jrbd_pkg::ST_EMIT;
          else if (n_in == '0)                          state_nxt = jrbd_pkg::ST_ROUND;
          else                                          state_nxt = jrbd_pkg::ST_SCALE;
        end
      end
      jrbd_pkg::ST_SCALE: begin
        if (div_sts.done) state_nxt = jrbd_pkg::ST_ROUND;
      end
      jrbd_pkg::ST_ROUND: begin
        state_nxt = (n_r == '0) ? jrbd_pkg::ST_EMIT : jrbd_pkg::ST_QUOT;
      end
      jrbd_pkg::ST_QUOT: begin
        if (div_sts.done) state_nxt = reject ? jrbd_pkg::ST_ROUND : jrbd_pkg::ST_EMIT;
      end
      jrbd_pkg::ST_EMIT: begin
        if (slot_free) state_nxt = jrbd_pkg::ST_IDLE;
      end
      default: state_nxt = jrbd_pkg::ST_IDLE;
    endcase
  end

  // Handshakes and divider requests.
  always_comb begin
    cfg_wr.ready     = (state_r == jrbd_pkg::ST_IDLE);
    in_req.ready     = (state_r == jrbd_pkg::ST_IDLE) && !cfg_wr.valid;
    div_req.start    = 1'b0;
    div_req.dividend = jrbd_pkg::JRBD_ALL_ONES;
    div_req.divisor  = n_in;
    unique case (state_r)
      jrbd_pkg::ST_IDLE: begin
        div_req.start = in_req.valid && !cfg_wr.valid && (n_in != '0) &&
                        !(op_in == jrbd_pkg::OP_RANGE && empty_rng);
      end
      jrbd_pkg::ST_ROUND: begin
        div_req.start    = (n_r != '0);
        div_req.dividend = d_n;
        div_req.divisor  = scale_r;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  assign req_acc = in_req.valid && in_req.ready;
  assign cfg_acc = cfg_wr.valid && cfg_wr.ready;

  jrbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Control and generator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jrbd_pkg::ST_WARM;
      warm_cnt_r  <= jrbd_pkg::JRBD_WARMUP;
      a_r         <= jrbd_pkg::JRBD_MAGIC;
      b_r         <= jrbd_pkg::JRBD_RESET_SEED;
      c_r         <= jrbd_pkg::JRBD_RESET_SEED;
      d_r         <= jrbd_pkg::JRBD_RESET_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        warm_cnt_r <= jrbd_pkg::JRBD_WARMUP;
        a_r        <= jrbd_pkg::JRBD_MAGIC;
        b_r        <= cfg_wr.seed_value;
        c_r        <= cfg_wr.seed_value;
        d_r        <= cfg_wr.seed_value;
      end else if (state_r == jrbd_pkg::ST_WARM || state_r == jrbd_pkg::ST_ROUND) begin
        a_r <= a_n;
        b_r <= b_n;
        c_r <= c_n;
        d_r <= d_n;
        if (state_r == jrbd_pkg::ST_WARM) warm_cnt_r <= warm_cnt_r - 5'd1;
      end
      if (state_r == jrbd_pkg::ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload and result.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      op_r     <= op_in;
      n_r      <= n_in;
      offset_r <= offset_in;
      limit_r  <= limit_in;
      value_r  <= in_req.range_low;
      hit_r    <= 1'b0;
    end
    if (state_r == jrbd_pkg::ST_SCALE && div_sts.done) begin
      scale_r <= div_q;
    end
    if (state_r == jrbd_pkg::ST_ROUND && n_r == '0) begin
      value_r <= d_n + offset_r;
      hit_r   <= 1'b0;
    end
    if (state_r == jrbd_pkg::ST_QUOT && div_sts.done && !reject) begin
      value_r <= div_q + offset_r;
      hit_r   <= (op_r == jrbd_pkg::OP_CHANCE) && (div_q < {25'd0, limit_r});
    end
    if (state_r == jrbd_pkg::ST_EMIT && slot_free) begin
      out_value_r <= value_r;
      out_hit_r   <= hit_r;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_value = out_value_r;
  assign out_rsp.chance_hit   = out_hit_r;

  // The divider is only started when idle.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // A divide only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == jrbd_pkg::ST_SCALE || state_r == jrbd_pkg::ST_QUOT))
    else $error("divider result arrived outside a wait state");

  // A seed write restarts the full warm-up.
  a_seed_warm: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (state_r == jrbd_pkg::ST_WARM && warm_cnt_r == jrbd_pkg::JRBD_WARMUP))
    else $error("seed write did not restart warm-up");

  // Leaving the emit state always presents a result.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jrbd_pkg::ST_EMIT && slot_free) |=> out_valid_r)
    else $error("result lost on emit");

endmodule

`default_nettype wire
